// ----- design/cts_pkg.sv -----
`timescale 1ns / 1ps
package cts_pkg;

    localparam int WINDOW     = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int HALF_WIN   = WINDOW / 2;
    localparam int LINES      = WINDOW - 1;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 12;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int CODE_W     = WINDOW * WINDOW - 1;
    localparam int OUT_CODE_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int M_TDATA_W  = ((OUT_CODE_W + ROW_W + COL_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

    typedef logic [PIX_W-1:0]          t_pix;
    typedef t_pix [WINDOW-1:0]         t_col;
    typedef t_col [WINDOW-1:0]         t_win;
    typedef t_pix [LINES-1:0]          t_lines;

endpackage

// ----- design/census_transform_stream_top.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: pixel; tuser: frame_start
// m_axis    out  m_axis_tvalid/tready        tdata: census_code, center_row, center_col
//                                            tlast: frame_last
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item per clock while the output is not stalled. A taken pixel enters stage 1 with
// its registered line store read; window update and compare load the output register.
// Line stores are uninitialized block RAM; no clearing pass after reset.
// Reset (synchronous, active low) clears counters, window, pipeline valids, config.
// An output stall backs up into the pixel side only once the stage before the
// output register holds a code too.
module census_transform_stream_top
    import cts_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]              s_axis_tuser,   // [0] frame_start
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_W-1:0]    m_axis_tdata,   // census_code, center_row, center_col
    output logic                    m_axis_tlast,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [CFG_W_W-1:0] r_cfg_width;
    logic [CFG_H_W-1:0] r_cfg_height;
    logic [EW_W-1:0]    eff_w;
    logic [ROW_W-1:0]   eff_h;

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   acc_col_raw, acc_col;
    logic [ROW_W-1:0]   acc_row;
    logic [EW_W-1:0]    col_inc;
    logic [ROW_W:0]     row_inc;
    logic               acc_emit, acc_last, accept;

    logic               r_s1_valid, r_s1_emit, r_s1_last;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    t_pix               r_s1_pix;
    logic               s1_go, s1_fire;

    t_lines             ram_q;
    t_lines             wr_data;
    logic               r_fwd;
    t_lines             r_fwd_data;
    t_col               col_data;
    t_win               r_win, n_win;
    logic [CODE_W-1:0]  code;

    logic                  r_out_valid, r_out_last;
    logic [OUT_CODE_W-1:0] r_out_code;
    logic [ROW_W-1:0]      r_out_row;
    logic [COL_W-1:0]      r_out_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_cfg_width) < 32'(WINDOW)) begin
            eff_w = EW_W'(WINDOW);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(r_cfg_width);
        end
        if (32'(r_cfg_height) < 32'(WINDOW)) begin
            eff_h = ROW_W'(WINDOW);
        end else begin
            eff_h = ROW_W'(r_cfg_height);
        end
    end

    // input side: raster position of the incoming pixel
    always_comb begin
        acc_col_raw = s_axis_tuser[0] ? '0 : r_col;
        acc_row     = s_axis_tuser[0] ? '0 : r_row;
        if (EW_W'(acc_col_raw) >= eff_w) begin
            acc_col = COL_W'(eff_w - EW_W'(1));
        end else begin
            acc_col = acc_col_raw;
        end
        col_inc  = EW_W'(acc_col) + EW_W'(1);
        row_inc  = (ROW_W+1)'(acc_row) + (ROW_W+1)'(1);
        acc_emit = (acc_row >= ROW_W'(WINDOW - 1)) && (acc_col >= COL_W'(WINDOW - 1));
        acc_last = (col_inc == eff_w) && (acc_row == eff_h - ROW_W'(1));
        if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = (row_inc >= (ROW_W+1)'(eff_h)) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = acc_row;
        end
    end

    assign s1_go         = !r_s1_emit || !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s1_go;
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
                r_fwd      <= r_s1_valid && (acc_col == r_s1_col);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= acc_col;
            r_s1_row   <= acc_row;
            r_s1_pix   <= s_axis_tdata;
            r_s1_emit  <= acc_emit;
            r_s1_last  <= acc_last;
            r_fwd_data <= wr_data;
        end
    end

    // line stores, oldest row first
    for (genvar g = 0; g < LINES; g++) begin : g_line
        cts_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (s1_fire),
            .i_waddr (r_s1_col),
            .i_wdata (wr_data[g]),
            .i_re    (accept),
            .i_raddr (acc_col),
            .o_rdata (ram_q[g])
        );
    end

    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            col_data[r] = r_fwd ? r_fwd_data[r] : ram_q[r];
        end
        col_data[WINDOW-1] = r_s1_pix;
        for (int r = 0; r < LINES; r++) begin
            wr_data[r] = col_data[r+1];
        end
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
            n_win[r][WINDOW-1] = col_data[r];
        end
        code = '0;
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW; c++) begin
                if (r != HALF_WIN || c != HALF_WIN) begin
                    code = {code[CODE_W-2:0], n_win[r][c] >= n_win[HALF_WIN][HALF_WIN]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_win <= n_win;
                if (r_s1_emit) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_code <= code[OUT_CODE_W-1:0];
            r_out_row  <= r_s1_row - ROW_W'(HALF_WIN);
            r_out_col  <= r_s1_col - COL_W'(HALF_WIN);
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_col, r_out_row, r_out_code});
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- design/cts_ram.sv -----
`timescale 1ns / 1ps
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cts_checker.sv -----
`timescale 1ns / 1ps
module cts_checker
    import cts_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]              s_axis_tuser,   // [0] frame_start
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [M_TDATA_W-1:0]    m_axis_tdata,   // census_code, center_row, center_col
    input  logic                    m_axis_tlast,
    input  logic                    i_cfg_valid,
    input  logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with output register empty");

    a_last_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[OUT_CODE_W +: ROW_W] >= ROW_W'(HALF_WIN)) &&
            (m_axis_tdata[OUT_CODE_W + ROW_W +: COL_W] >= COL_W'(HALF_WIN)))
        else $error("frame end flagged on a border position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind census_transform_stream_top cts_checker u_cts_checker (.*);
